FILE: rtl/psmp_pkg.sv
// Shared constants, codes and types for the paged serial memory pack.
package psmp_pkg;

    localparam int STORE_ADDR_BITS_DEF = 16;
    localparam int ADDR_W = 23;

    localparam int OPCODE_W  = 3;
    localparam int BYTE_W    = 8;
    localparam int PRE_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;
    localparam int LEN_W     = 17;
    localparam int BYTE_CNT_W = 21;
    localparam int PAGE_CNT_W = 13;

    localparam logic [OPCODE_W-1:0] OP_WR_CTRL = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_WR_DATA = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_RD_DATA = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_RD_CTRL = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PRELOAD = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PACK_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CATALOGUE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 3'd4;

    localparam int LINE_CLOCK   = 0;
    localparam int LINE_RESET   = 1;
    localparam int LINE_PROGRAM = 2;
    localparam int LINE_OE      = 3;
    localparam int LINE_SS      = 4;

    localparam int ID_EPROM = 1;
    localparam int ID_PAGED = 2;
    localparam int ID_WRITE = 3;

    localparam logic [BYTE_W-1:0] RAM_PACK_ID = 8'h01;
    localparam logic [BYTE_W-1:0] BLANK_BYTE  = 8'hFF;
    localparam logic [BYTE_CNT_W-1:0] PAGE_BYTES = 21'h100;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] value;
    } t_push;

    function automatic logic [BYTE_W-1:0] seg_mask(input logic [BYTE_W-1:0] size);
        logic [BYTE_W-1:0] m;
        if (size <= 8'h10) begin
            m = 8'h07;
        end else if (size <= 8'h20) begin
            m = 8'h0F;
        end else if (size <= 8'h40) begin
            m = 8'h1F;
        end else if (size <= 8'h80) begin
            m = 8'h3F;
        end else begin
            m = 8'hFF;
        end
        return m;
    endfunction

endpackage

FILE: rtl/psmp_ifs.sv
// Valid/ready channel interfaces: bus items, results and configuration writes.
interface psmp_item_if;
    logic                            valid;
    logic                            ready;
    logic [psmp_pkg::OPCODE_W-1:0]   opcode;
    logic [psmp_pkg::BYTE_W-1:0]     bus_value;
    logic [psmp_pkg::PRE_W-1:0]      preload_addr;

    modport source (output valid, output opcode, output bus_value, output preload_addr,
                    input ready);
    modport sink (input valid, input opcode, input bus_value, input preload_addr,
                  output ready);
endinterface

interface psmp_result_if;
    logic                        valid;
    logic                        ready;
    logic [psmp_pkg::BYTE_W-1:0] read_value;

    modport source (output valid, output read_value, input ready);
    modport sink (input valid, input read_value, output ready);
endinterface

interface psmp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [psmp_pkg::CFG_IDX_W-1:0] index;
    logic [psmp_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/paged_serial_memory_pack.sv
// Top level of the paged serial memory pack.
// Throughput: one transaction per cycle while the result queue has room;
// each uses the store at most once, and its result is registered in the queue.
// Store read data is registered, forwarded, then copied into the data latch.
// Reset (synchronous, active low) clears registers, counters and latches;
// store content stays undefined until written, with no clearing pass.
module paged_serial_memory_pack #(
    parameter int STORE_ADDR_BITS = psmp_pkg::STORE_ADDR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psmp_item_if.sink     i_item,
    psmp_result_if.source o_result,
    psmp_cfg_if.sink      i_cfg
);

    psmp_pkg::t_push push;
    logic            can_push;

    psmp_core #(
        .STORE_ADDR_BITS (STORE_ADDR_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg      (i_cfg),
        .i_can_push (can_push),
        .o_push     (push)
    );

    psmp_out_q u_out_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_can_push (can_push),
        .o_result   (o_result)
    );

endmodule

FILE: rtl/psmp_ram.sv
// Generic single-clock RAM, one write and one read port, registered read data.
module psmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/psmp_out_q.sv
// Two-entry result queue between the access logic and the result channel.
module psmp_out_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psmp_pkg::t_push  i_push,
    output logic             o_can_push,
    psmp_result_if.source    o_result
);

    logic [psmp_pkg::BYTE_W-1:0] r_q [2];
    logic                        r_wp;
    logic                        r_rp;
    logic [1:0]                  r_cnt;
    logic                        pop;

    assign pop        = o_result.valid && o_result.ready;
    assign o_can_push = (r_cnt != 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_q[r_wp] <= i_push.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push.valid, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_result.valid      = (r_cnt != 2'd0);
    assign o_result.read_value = r_q[r_rp];

endmodule

FILE: rtl/psmp_core.sv
// Bus access logic: control lines, counters, latches and the pack store.
module psmp_core #(
    parameter int STORE_ADDR_BITS = psmp_pkg::STORE_ADDR_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    psmp_item_if.sink       i_item,
    psmp_cfg_if.sink        i_cfg,
    input  logic            i_can_push,
    output psmp_pkg::t_push o_push
);

    localparam int DEPTH = 1 << STORE_ADDR_BITS;
    localparam int AW    = psmp_pkg::ADDR_W;
    localparam int BW    = psmp_pkg::BYTE_W;

    logic [BW-1:0]                   r_pack_id, n_pack_id;
    logic [BW-1:0]                   r_size, n_size;
    logic                            r_present, n_present;
    logic                            r_catalogue, n_catalogue;
    logic [psmp_pkg::LEN_W-1:0]      r_length, n_length;
    logic [psmp_pkg::BYTE_CNT_W-1:0] r_byte, n_byte;
    logic [psmp_pkg::PAGE_CNT_W-1:0] r_page, n_page;
    logic [BW-1:0]                   r_seg, n_seg;
    logic [BW-1:0]                   r_ctl, n_ctl;
    logic [BW-1:0]                   r_dl, n_dl;
    logic                            r_pend, n_pend;
    logic                            r_pend_ff, n_pend_ff;

    logic [BW-1:0]                   eff_dl;
    logic [BW-1:0]                   ram_rdata;
    logic                            ram_we;
    logic                            ram_re;
    logic [AW-1:0]                   ram_addr_ext;
    logic [BW-1:0]                   ram_wdata;
    logic                            accept;
    logic                            act;
    logic [BW-1:0]                   result;
    logic [AW-1:0]                   addr;
    logic [AW-1:0]                   limit;
    logic                            in_store;
    logic [psmp_pkg::BYTE_CNT_W-1:0] byte_lim;
    logic [psmp_pkg::PAGE_CNT_W-1:0] page_lim;

    assign i_item.ready = i_can_push;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_item.valid && i_item.ready;

    // forward the store read issued by the previous transaction
    assign eff_dl = r_pend ? (r_pend_ff ? psmp_pkg::BLANK_BYTE : ram_rdata) : r_dl;

    always_comb begin
        n_pack_id   = r_pack_id;
        n_size      = r_size;
        n_present   = r_present;
        n_catalogue = r_catalogue;
        n_length    = r_length;
        n_byte      = r_byte;
        n_page      = r_page;
        n_seg       = r_seg;
        n_ctl       = r_ctl;
        n_dl        = eff_dl;
        n_pend      = 1'b0;
        n_pend_ff   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = eff_dl;
        act         = 1'b0;
        result      = '0;
        addr        = '0;
        limit       = '0;
        in_store    = 1'b0;
        byte_lim    = '0;
        page_lim    = '0;
        ram_addr_ext = AW'(i_item.preload_addr);

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                psmp_pkg::CFG_PACK_ID:   n_pack_id   = i_cfg.data[BW-1:0];
                psmp_pkg::CFG_SIZE:      n_size      = i_cfg.data[BW-1:0];
                psmp_pkg::CFG_PRESENT:   n_present   = i_cfg.data[0];
                psmp_pkg::CFG_CATALOGUE: n_catalogue = i_cfg.data[0];
                psmp_pkg::CFG_LENGTH:    n_length    = i_cfg.data[psmp_pkg::LEN_W-1:0];
                default: ;
            endcase
        end

        if (accept) begin
            unique case (i_item.opcode)
                psmp_pkg::OP_WR_CTRL: begin
                    if (r_present) begin
                        if (r_ctl[psmp_pkg::LINE_CLOCK]
                            != i_item.bus_value[psmp_pkg::LINE_CLOCK]) begin
                            byte_lim = r_pack_id[psmp_pkg::ID_PAGED] ? psmp_pkg::PAGE_BYTES
                                                                     : {r_size, 13'd0};
                            n_byte = r_byte + 1'b1;
                            if (n_byte >= byte_lim) begin
                                n_byte = '0;
                            end
                        end
                        if (r_ctl[psmp_pkg::LINE_PROGRAM]
                            && !i_item.bus_value[psmp_pkg::LINE_PROGRAM]) begin
                            page_lim = {r_size, 5'd0};
                            n_page = r_page + 1'b1;
                            if (n_page >= page_lim) begin
                                n_page = '0;
                            end
                        end
                        if (i_item.bus_value[psmp_pkg::LINE_RESET]) begin
                            n_byte = '0;
                            n_page = '0;
                        end
                        n_ctl = i_item.bus_value;
                        act   = !i_item.bus_value[psmp_pkg::LINE_SS];
                    end
                end
                psmp_pkg::OP_WR_DATA: begin
                    if (r_present) begin
                        n_dl = i_item.bus_value;
                        act  = !i_item.bus_value[psmp_pkg::LINE_SS];
                    end
                end
                psmp_pkg::OP_RD_DATA: begin
                    result = r_ctl[psmp_pkg::LINE_SS] ? '0 : eff_dl;
                end
                psmp_pkg::OP_RD_CTRL: begin
                    result = r_ctl;
                end
                psmp_pkg::OP_PRELOAD: begin
                    ram_we    = 1'b1;
                    ram_wdata = i_item.bus_value;
                end
                default: ;
            endcase
        end

        if (act) begin
            addr = AW'(n_byte);
            if (r_pack_id[psmp_pkg::ID_PAGED]) begin
                addr = addr + (AW'(n_page) << 8);
            end
            if (r_size >= 8'h10) begin
                addr = addr + (AW'(r_seg) << 14);
            end
            limit    = AW'(r_size) << 13;
            in_store = ((addr >> STORE_ADDR_BITS) == '0);
            if (addr < limit) begin
                if (n_ctl[psmp_pkg::LINE_OE] && !n_ctl[psmp_pkg::LINE_RESET]) begin
                    if (!r_catalogue && r_pack_id[psmp_pkg::ID_WRITE] && in_store) begin
                        ram_we       = 1'b1;
                        ram_wdata    = n_dl;
                        ram_addr_ext = addr;
                        if (addr >= AW'(r_length)) begin
                            n_length = psmp_pkg::LEN_W'(addr + 1'b1);
                        end
                    end
                end else if (n_ctl[psmp_pkg::LINE_OE]) begin
                    n_seg = n_dl & psmp_pkg::seg_mask(r_size);
                end else if (!n_ctl[psmp_pkg::LINE_RESET]) begin
                    ram_re       = 1'b1;
                    ram_addr_ext = addr;
                    n_pend       = 1'b1;
                    n_pend_ff    = !((addr < AW'(r_length)) && in_store);
                end else begin
                    n_dl = (r_pack_id[psmp_pkg::ID_EPROM] || r_catalogue)
                           ? r_pack_id : psmp_pkg::RAM_PACK_ID;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_id   <= '0;
            r_size      <= '0;
            r_present   <= 1'b0;
            r_catalogue <= 1'b0;
            r_length    <= '0;
            r_byte      <= '0;
            r_page      <= '0;
            r_seg       <= '0;
            r_ctl       <= '0;
            r_dl        <= '0;
            r_pend      <= 1'b0;
            r_pend_ff   <= 1'b0;
        end else begin
            r_pack_id   <= n_pack_id;
            r_size      <= n_size;
            r_present   <= n_present;
            r_catalogue <= n_catalogue;
            r_length    <= n_length;
            r_byte      <= n_byte;
            r_page      <= n_page;
            r_seg       <= n_seg;
            r_ctl       <= n_ctl;
            r_dl        <= n_dl;
            r_pend      <= n_pend;
            r_pend_ff   <= n_pend_ff;
        end
    end

    assign o_push.valid = accept;
    assign o_push.value = result;

    psmp_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr_ext[STORE_ADDR_BITS-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr_ext[STORE_ADDR_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

endmodule

FILE: tb/paged_serial_memory_pack_tb.sv
// Self-checking testbench for the paged serial memory pack: directed table, then random traffic.
module paged_serial_memory_pack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 1 << psmp_pkg::STORE_ADDR_BITS_DEF;
    localparam int ITEM_GOAL   = 1790;
    localparam int STEADY_TAIL = 250;
    localparam int CYCLE_LIMIT = 500_000;

    localparam logic [psmp_pkg::OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [psmp_pkg::OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [psmp_pkg::BYTE_W-1:0] CTL_CLK = 8'(1 << psmp_pkg::LINE_CLOCK);
    localparam logic [psmp_pkg::BYTE_W-1:0] CTL_RST = 8'(1 << psmp_pkg::LINE_RESET);
    localparam logic [psmp_pkg::BYTE_W-1:0] CTL_PGM = 8'(1 << psmp_pkg::LINE_PROGRAM);
    localparam logic [psmp_pkg::BYTE_W-1:0] CTL_OE  = 8'(1 << psmp_pkg::LINE_OE);
    localparam logic [psmp_pkg::BYTE_W-1:0] CTL_SS  = 8'(1 << psmp_pkg::LINE_SS);

    typedef struct packed {
        logic [psmp_pkg::BYTE_W-1:0] id;
        logic [psmp_pkg::BYTE_W-1:0] size;
        logic                        present;
        logic                        catalogue;
        logic [psmp_pkg::LEN_W-1:0]  length;
    } t_pack_cfg;

    typedef struct packed {
        t_pack_cfg                       cfg;
        logic [psmp_pkg::BYTE_CNT_W-1:0] byte_cnt;
        logic [psmp_pkg::PAGE_CNT_W-1:0] page_cnt;
        logic [psmp_pkg::BYTE_W-1:0]     segment;
        logic [psmp_pkg::BYTE_W-1:0]     ctrl;
        logic [psmp_pkg::BYTE_W-1:0]     data;
    } t_pack_state;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CHECK, ROW_SETUP} t_row_kind;

    typedef struct {
        t_row_kind                     kind;
        logic [psmp_pkg::OPCODE_W-1:0] op;
        logic [psmp_pkg::BYTE_W-1:0]   value;
        logic [psmp_pkg::PRE_W-1:0]    addr;
        logic [psmp_pkg::BYTE_W-1:0]   want;
        t_pack_cfg                     setting;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    psmp_item_if   item_ch();
    psmp_result_if result_ch();
    psmp_cfg_if    cfg_ch();

    paged_serial_memory_pack u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    t_pack_state                 pack_model;
    logic [psmp_pkg::BYTE_W-1:0] pack_mem [STORE_DEPTH];
    bit                          pack_written [STORE_DEPTH];
    logic [psmp_pkg::BYTE_W-1:0] pending_reads [$];
    logic [psmp_pkg::BYTE_W-1:0] want_value;
    t_row                        stim_rows [$];
    logic [psmp_pkg::BYTE_W-1:0] size_picks [14] = '{8'd0, 8'd1, 8'd2, 8'd8, 8'd15, 8'd16,
                                                     8'd17, 8'd32, 8'd33, 8'd64, 8'd65,
                                                     8'd128, 8'd129, 8'd255};

    int          mismatches;
    int          cycle_count;
    int          items_sent;
    int unsigned tx_odds;
    int unsigned rx_odds;
    int unsigned rx_hold;
    bit          steady;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [psmp_pkg::BYTE_W-1:0] got,
                                   input logic [psmp_pkg::BYTE_W-1:0] want);
        mismatches++;
        $display("[%0t] MISMATCH %s: got %02h, want %02h", $time, what, got, want);
    endtask

    function automatic void pack_access(inout t_pack_state s, input bit commit,
                                        output bit blank, output int unsigned blank_addr);
        int unsigned addr;
        logic [psmp_pkg::BYTE_W-1:0] m;
        blank = 1'b0;
        blank_addr = 0;
        addr = 32'(s.byte_cnt);
        if (s.cfg.id[psmp_pkg::ID_PAGED]) addr = addr + (32'(s.page_cnt) << 8);
        if (s.cfg.size >= 8'h10) addr = addr + (32'(s.segment) << 14);
        if (addr >= (32'(s.cfg.size) << 13)) return;
        if (s.ctrl[psmp_pkg::LINE_OE] && !s.ctrl[psmp_pkg::LINE_RESET]) begin
            if (!s.cfg.catalogue && s.cfg.id[psmp_pkg::ID_WRITE] && addr < STORE_DEPTH) begin
                if (commit) begin
                    pack_mem[addr] = s.data;
                    pack_written[addr] = 1'b1;
                end
                if (addr >= 32'(s.cfg.length)) s.cfg.length = 17'(addr + 1);
            end
        end else if (s.ctrl[psmp_pkg::LINE_OE]) begin
            if (s.cfg.size <= 8'h10) m = 8'h07;
            else if (s.cfg.size <= 8'h20) m = 8'h0F;
            else if (s.cfg.size <= 8'h40) m = 8'h1F;
            else if (s.cfg.size <= 8'h80) m = 8'h3F;
            else m = 8'hFF;
            s.segment = s.data & m;
        end else if (!s.ctrl[psmp_pkg::LINE_RESET]) begin
            if (addr < 32'(s.cfg.length) && addr < STORE_DEPTH) begin
                if (!pack_written[addr]) begin
                    blank = 1'b1;
                    blank_addr = addr;
                end
                s.data = pack_mem[addr];
            end else begin
                s.data = psmp_pkg::BLANK_BYTE;
            end
        end else begin
            s.data = (s.cfg.id[psmp_pkg::ID_EPROM] || s.cfg.catalogue)
                     ? s.cfg.id : psmp_pkg::RAM_PACK_ID;
        end
    endfunction

    function automatic logic [psmp_pkg::BYTE_W-1:0] advance_pack(inout t_pack_state s,
            input logic [psmp_pkg::OPCODE_W-1:0] op, input logic [psmp_pkg::BYTE_W-1:0] v,
            input logic [psmp_pkg::PRE_W-1:0] pa, input bit commit,
            output bit blank, output int unsigned blank_addr);
        logic [psmp_pkg::BYTE_W-1:0] r;
        int unsigned lim;
        r = '0;
        blank = 1'b0;
        blank_addr = 0;
        case (op)
            psmp_pkg::OP_WR_CTRL: begin
                if (s.cfg.present) begin
                    if (s.ctrl[psmp_pkg::LINE_CLOCK] != v[psmp_pkg::LINE_CLOCK]) begin
                        lim = s.cfg.id[psmp_pkg::ID_PAGED] ? 32'h100 : (32'(s.cfg.size) << 13);
                        s.byte_cnt = s.byte_cnt + 1'b1;
                        if (32'(s.byte_cnt) >= lim) s.byte_cnt = '0;
                    end
                    if (s.ctrl[psmp_pkg::LINE_PROGRAM] && !v[psmp_pkg::LINE_PROGRAM]) begin
                        lim = 32'(s.cfg.size) << 5;
                        s.page_cnt = s.page_cnt + 1'b1;
                        if (32'(s.page_cnt) >= lim) s.page_cnt = '0;
                    end
                    if (v[psmp_pkg::LINE_RESET]) begin
                        s.byte_cnt = '0;
                        s.page_cnt = '0;
                    end
                    s.ctrl = v;
                    if (!v[psmp_pkg::LINE_SS]) pack_access(s, commit, blank, blank_addr);
                end
            end
            psmp_pkg::OP_WR_DATA: begin
                if (s.cfg.present) begin
                    s.data = v;
                    if (!v[psmp_pkg::LINE_SS]) pack_access(s, commit, blank, blank_addr);
                end
            end
            psmp_pkg::OP_RD_DATA: begin
                r = s.ctrl[psmp_pkg::LINE_SS] ? 8'h00 : s.data;
            end
            psmp_pkg::OP_RD_CTRL: begin
                r = s.ctrl;
            end
            psmp_pkg::OP_PRELOAD: begin
                if (commit) begin
                    pack_mem[pa] = v;
                    pack_written[pa] = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic put_item(input logic [psmp_pkg::OPCODE_W-1:0] op,
                            input logic [psmp_pkg::BYTE_W-1:0] v,
                            input logic [psmp_pkg::PRE_W-1:0] pa, input bit typed,
                            input logic [psmp_pkg::BYTE_W-1:0] want);
        logic [psmp_pkg::BYTE_W-1:0] r;
        bit blank;
        int unsigned blank_addr;
        if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= op;
        item_ch.bus_value    <= v;
        item_ch.preload_addr <= pa;
        do @(posedge i_clk); while (!item_ch.ready);
        r = advance_pack(pack_model, op, v, pa, 1'b1, blank, blank_addr);
        pending_reads.push_back(typed ? want : r);
        items_sent++;
    endtask

    // fill a never-written entry before the access that would read it
    task automatic send_item(input logic [psmp_pkg::OPCODE_W-1:0] op,
                             input logic [psmp_pkg::BYTE_W-1:0] v,
                             input logic [psmp_pkg::PRE_W-1:0] pa, input bit typed,
                             input logic [psmp_pkg::BYTE_W-1:0] want);
        t_pack_state trial;
        bit blank;
        int unsigned blank_addr;
        trial = pack_model;
        void'(advance_pack(trial, op, v, pa, 1'b0, blank, blank_addr));
        if (blank) begin
            put_item(psmp_pkg::OP_PRELOAD, 8'($urandom_range(0, 255)), 16'(blank_addr),
                     1'b0, '0);
        end
        put_item(op, v, pa, typed, want);
    endtask

    task automatic program_pack(input t_pack_cfg c);
        logic [psmp_pkg::CFG_DAT_W-1:0] vals [5];
        logic [psmp_pkg::CFG_IDX_W-1:0] idx [5];
        int k;
        item_ch.valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        vals = '{17'(c.id), 17'(c.size), 17'(c.present), 17'(c.catalogue), c.length};
        idx = '{psmp_pkg::CFG_PACK_ID, psmp_pkg::CFG_SIZE, psmp_pkg::CFG_PRESENT,
                psmp_pkg::CFG_CATALOGUE, psmp_pkg::CFG_LENGTH};
        for (k = 0; k < 5; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[k];
            cfg_ch.data  <= vals[k];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        pack_model.cfg = c;
    endtask

    task automatic run_burst();
        int kind;
        int n;
        logic [psmp_pkg::BYTE_W-1:0] lines;
        logic [psmp_pkg::BYTE_W-1:0] d;
        kind = $urandom_range(0, 9);
        n = $urandom_range(1, 8);
        repeat (n) begin
            lines = 8'($urandom_range(0, 255));
            lines[psmp_pkg::LINE_CLOCK] = ~pack_model.ctrl[psmp_pkg::LINE_CLOCK];
            lines[psmp_pkg::LINE_SS] = ($urandom_range(0, 7) == 0);
            lines[psmp_pkg::LINE_RESET] = ($urandom_range(0, 9) == 0);
            d = 8'($urandom_range(0, 255));
            d[psmp_pkg::LINE_SS] = ($urandom_range(0, 5) == 0);
            case (kind)
                0, 1: begin
                    lines[psmp_pkg::LINE_OE] = 1'b0;
                    send_item(psmp_pkg::OP_WR_CTRL, lines, 16'($urandom), 1'b0, '0);
                    send_item(psmp_pkg::OP_RD_DATA, 8'($urandom), 16'($urandom), 1'b0, '0);
                end
                2, 3: begin
                    lines[psmp_pkg::LINE_OE] = 1'b1;
                    send_item(psmp_pkg::OP_WR_CTRL, lines, 16'($urandom), 1'b0, '0);
                    send_item(psmp_pkg::OP_WR_DATA, d, 16'($urandom), 1'b0, '0);
                end
                4: begin
                    lines[psmp_pkg::LINE_OE] = 1'b0;
                    lines[psmp_pkg::LINE_RESET] = 1'b1;
                    send_item(psmp_pkg::OP_WR_CTRL, lines, 16'($urandom), 1'b0, '0);
                    send_item(psmp_pkg::OP_RD_DATA, 8'($urandom), 16'($urandom), 1'b0, '0);
                    send_item(psmp_pkg::OP_RD_CTRL, 8'($urandom), 16'($urandom), 1'b0, '0);
                end
                5: begin
                    lines[psmp_pkg::LINE_OE] = 1'b1;
                    lines[psmp_pkg::LINE_RESET] = 1'b1;
                    send_item(psmp_pkg::OP_WR_CTRL, lines, 16'($urandom), 1'b0, '0);
                    send_item(psmp_pkg::OP_WR_DATA, d, 16'($urandom), 1'b0, '0);
                end
                6: begin
                    lines[psmp_pkg::LINE_PROGRAM] = 1'b1;
                    send_item(psmp_pkg::OP_WR_CTRL, lines, 16'($urandom), 1'b0, '0);
                    lines[psmp_pkg::LINE_PROGRAM] = 1'b0;
                    lines[psmp_pkg::LINE_CLOCK] = ~lines[psmp_pkg::LINE_CLOCK];
                    send_item(psmp_pkg::OP_WR_CTRL, lines, 16'($urandom), 1'b0, '0);
                end
                7: begin
                    send_item(psmp_pkg::OP_PRELOAD, d, ($urandom_range(0, 3) != 0) ?
                              16'($urandom_range(0, 1023)) : 16'($urandom), 1'b0, '0);
                end
                default: begin
                    send_item(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom), 1'b0, '0);
                end
            endcase
        end
    endtask

    function automatic t_row item_row(input logic [psmp_pkg::OPCODE_W-1:0] op,
                                      input logic [psmp_pkg::BYTE_W-1:0] v,
                                      input logic [psmp_pkg::PRE_W-1:0] pa);
        t_row r;
        r.kind = ROW_ITEM;
        r.op = op;
        r.value = v;
        r.addr = pa;
        r.want = '0;
        r.setting = '0;
        return r;
    endfunction

    function automatic t_row check_row(input logic [psmp_pkg::OPCODE_W-1:0] op,
                                       input logic [psmp_pkg::BYTE_W-1:0] v,
                                       input logic [psmp_pkg::PRE_W-1:0] pa,
                                       input logic [psmp_pkg::BYTE_W-1:0] want);
        t_row r;
        r = item_row(op, v, pa);
        r.kind = ROW_CHECK;
        r.want = want;
        return r;
    endfunction

    function automatic t_row setup_row(input logic [psmp_pkg::BYTE_W-1:0] id,
                                       input logic [psmp_pkg::BYTE_W-1:0] size,
                                       input logic present, input logic catalogue,
                                       input logic [psmp_pkg::LEN_W-1:0] length);
        t_row r;
        r = item_row(psmp_pkg::OP_RD_CTRL, '0, '0);
        r.kind = ROW_SETUP;
        r.setting = '{id, size, present, catalogue, length};
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            result_ch.ready <= 1'b0;
        end else if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
            rx_hold <= $urandom_range(0, 13);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_reads.size() == 0) begin
                report_mismatch("read_value with nothing pending", result_ch.read_value, 'x);
            end else begin
                want_value = pending_reads.pop_front();
                if (result_ch.read_value !== want_value) begin
                    report_mismatch("read_value", result_ch.read_value, want_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_pack_cfg setting;
        int phase_end;
        i_rst_n              = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.opcode       = psmp_pkg::OP_RD_CTRL;
        item_ch.bus_value    = '0;
        item_ch.preload_addr = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = psmp_pkg::CFG_PACK_ID;
        cfg_ch.data          = '0;
        result_ch.ready      = 1'b1;
        pack_model           = '0;
        mismatches           = 0;
        cycle_count          = 0;
        items_sent           = 0;
        rx_hold              = 0;
        steady               = 1'b0;
        tx_odds              = 3;
        rx_odds              = 3;

        stim_rows = '{
            check_row(psmp_pkg::OP_RD_CTRL, 8'h00, 16'h0000, 8'h00),
            check_row(psmp_pkg::OP_RD_DATA, 8'h00, 16'h0000, 8'h00),
            check_row(psmp_pkg::OP_WR_CTRL, 8'hFF, 16'hFFFF, 8'h00),
            check_row(psmp_pkg::OP_RD_CTRL, 8'h00, 16'h0000, 8'h00),
            check_row(OP_SPARE_7, 8'hFF, 16'hFFFF, 8'h00),
            check_row(psmp_pkg::OP_PRELOAD, 8'hA5, 16'hFFFF, 8'h00),
            check_row(psmp_pkg::OP_PRELOAD, 8'h00, 16'h0000, 8'h00),
            setup_row(8'h0E, 8'h01, 1'b1, 1'b0, 17'h10000),
            check_row(psmp_pkg::OP_WR_CTRL, CTL_OE | CTL_RST, 16'h0000, 8'h00),
            check_row(psmp_pkg::OP_WR_DATA, 8'h00, 16'h0000, 8'h00),
            check_row(psmp_pkg::OP_WR_CTRL, CTL_RST, 16'h0000, 8'h00),
            check_row(psmp_pkg::OP_RD_DATA, 8'h00, 16'h0000, 8'h0E),
            check_row(psmp_pkg::OP_RD_CTRL, 8'h00, 16'h0000, CTL_RST),
            check_row(psmp_pkg::OP_WR_CTRL, CTL_SS | CTL_RST, 16'h0000, 8'h00),
            check_row(psmp_pkg::OP_RD_DATA, 8'h00, 16'h0000, 8'h00),
            item_row(psmp_pkg::OP_WR_CTRL, CTL_OE, 16'h0000),
            item_row(psmp_pkg::OP_WR_DATA, 8'hEF, 16'h0000),
            item_row(psmp_pkg::OP_WR_DATA, 8'hFF, 16'h0000),
            item_row(psmp_pkg::OP_WR_CTRL, CTL_CLK, 16'h0000),
            item_row(psmp_pkg::OP_RD_DATA, 8'h00, 16'h0000),
            item_row(psmp_pkg::OP_WR_CTRL, CTL_PGM, 16'h0000),
            item_row(psmp_pkg::OP_WR_CTRL, 8'h00, 16'h0000),
            item_row(psmp_pkg::OP_RD_DATA, 8'h00, 16'h0000),
            check_row(OP_SPARE_5, 8'h5A, 16'h1234, 8'h00),
            setup_row(8'h00, 8'h01, 1'b1, 1'b0, 17'h00000),
            check_row(psmp_pkg::OP_WR_CTRL, CTL_RST, 16'h0000, 8'h00),
            check_row(psmp_pkg::OP_RD_DATA, 8'h00, 16'h0000, psmp_pkg::RAM_PACK_ID),
            check_row(psmp_pkg::OP_WR_CTRL, 8'h00, 16'h0000, 8'h00),
            check_row(psmp_pkg::OP_RD_DATA, 8'h00, 16'h0000, psmp_pkg::BLANK_BYTE),
            setup_row(8'h08, 8'h01, 1'b1, 1'b0, 17'h00000),
            item_row(psmp_pkg::OP_WR_DATA, 8'h3C, 16'h0000),
            item_row(psmp_pkg::OP_WR_CTRL, CTL_OE, 16'h0000),
            item_row(psmp_pkg::OP_WR_CTRL, 8'h00, 16'h0000),
            item_row(psmp_pkg::OP_RD_DATA, 8'h00, 16'h0000),
            setup_row(8'hFF, 8'hFF, 1'b1, 1'b1, 17'h10000),
            check_row(psmp_pkg::OP_WR_CTRL, CTL_RST, 16'h0000, 8'h00),
            check_row(psmp_pkg::OP_RD_DATA, 8'h00, 16'h0000, 8'hFF),
            item_row(psmp_pkg::OP_WR_CTRL, CTL_OE | CTL_RST, 16'h0000),
            item_row(psmp_pkg::OP_WR_DATA, 8'h07, 16'h0000),
            item_row(psmp_pkg::OP_WR_CTRL, CTL_OE, 16'h0000),
            item_row(psmp_pkg::OP_WR_CTRL, CTL_CLK, 16'h0000),
            item_row(psmp_pkg::OP_RD_DATA, 8'h00, 16'h0000),
            setup_row(8'h0E, 8'h00, 1'b1, 1'b0, 17'h10000),
            item_row(psmp_pkg::OP_WR_CTRL, CTL_CLK | CTL_PGM, 16'h0000),
            item_row(psmp_pkg::OP_WR_CTRL, 8'h00, 16'h0000),
            item_row(psmp_pkg::OP_RD_DATA, 8'h00, 16'h0000)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            case (stim_rows[i].kind)
                ROW_SETUP: begin
                    program_pack(stim_rows[i].setting);
                end
                ROW_CHECK: begin
                    send_item(stim_rows[i].op, stim_rows[i].value, stim_rows[i].addr,
                              1'b1, stim_rows[i].want);
                end
                default: begin
                    send_item(stim_rows[i].op, stim_rows[i].value, stim_rows[i].addr,
                              1'b0, '0);
                end
            endcase
        end

        while (items_sent < ITEM_GOAL) begin
            setting.id = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) setting.id[psmp_pkg::ID_WRITE] = 1'b1;
            setting.size = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                           size_picks[$urandom_range(0, 13)];
            setting.present = ($urandom_range(0, 9) != 0);
            setting.catalogue = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0: setting.length = 17'h00000;
                1: setting.length = 17'h10000;
                2: setting.length = 17'($urandom_range(0, 65536));
                default: setting.length = 17'($urandom_range(0, 600));
            endcase
            program_pack(setting);
            case ($urandom_range(0, 2))
                0: tx_odds = 0;
                1: tx_odds = 4;
                default: tx_odds = 12;
            endcase
            rx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
            phase_end = items_sent + $urandom_range(60, 220);
            while (items_sent < phase_end && items_sent < ITEM_GOAL) begin
                if (items_sent >= ITEM_GOAL - STEADY_TAIL) begin
                    steady = 1'b1;
                end
                if (steady) begin
                    tx_odds = 0;
                    rx_odds = 0;
                end
                run_burst();
            end
        end

        item_ch.valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/psmp_pkg.sv
rtl/psmp_ifs.sv
rtl/psmp_ram.sv
rtl/psmp_out_q.sv
rtl/psmp_core.sv
rtl/paged_serial_memory_pack.sv
tb/paged_serial_memory_pack_tb.sv
